[rtl/pbdt_pkg.sv]
// shared types and constants for the drop-tail packet buffer
package pbdt_pkg;

    // ring geometry
    localparam int BUF_DEPTH = 16;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // field widths
    localparam int ARRIVAL_W = 32;
    localparam int PTIME_W   = 16;
    localparam int TIME_W    = 33;
    localparam int SIZE_W    = 5;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0] BUFFER_SIZE_RESET = SIZE_W'(BUF_DEPTH);

    // saturated finish time
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DECIDE
    } state_t;

endpackage

[rtl/packet_buffer_drop_tail.sv]
// drop-tail packet buffer: head retire loop, admit decision and finish ring
// IDLE takes input; READ and CMP loop per retired entry; DECIDE waits for a free output
// a new packet is accepted only back in IDLE; each retire costs a ring read and a compare
// the shared 33-bit compare then the shared saturating adder set the step time
// a result waiting in the output register does not block the next input transfer
// reset (aresetn low, synchronous): ring empty, head zero, buffer_size 16, no result pending
module packet_buffer_drop_tail (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pbdt_pkg::S_TDATA_W-1:0] s_tdata,   // arrival[31:0], ptime[47:32]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pbdt_pkg::M_TDATA_W-1:0] m_tdata,   // start[32:0], zero pad[39:33]
    output logic                          m_tuser,   // dropped[0]
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbdt_pkg::PADDR_W-1:0]  paddr,
    input  logic [pbdt_pkg::PDATA_W-1:0]  pwdata,
    output logic [pbdt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    pbdt_pkg::state_t state_reg, state_next;

    logic [pbdt_pkg::IDX_W-1:0]     head_reg, head_next;
    logic [pbdt_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [pbdt_pkg::TIME_W-1:0]    last_reg, last_next;
    logic [pbdt_pkg::ARRIVAL_W-1:0] arrival_reg;
    logic [pbdt_pkg::PTIME_W-1:0]   ptime_reg;
    logic [pbdt_pkg::SIZE_W-1:0]    size_reg;
    logic                           m_valid_reg, m_valid_next;
    logic [pbdt_pkg::TIME_W-1:0]    m_start_reg, m_start_next;
    logic                           m_drop_reg, m_drop_next;
    logic [pbdt_pkg::TIME_W-1:0]    rd_data_reg;

    logic [pbdt_pkg::TIME_W-1:0]    ring_mem [pbdt_pkg::BUF_DEPTH];

    logic                           in_xfer;
    logic                           cfg_write;
    logic                           out_free;
    logic                           retire;
    logic                           ring_we;
    logic [pbdt_pkg::IDX_W-1:0]     tail_idx;
    logic [pbdt_pkg::CNT_W-1:0]     cap;
    logic                           empty;
    logic                           admit;
    logic [pbdt_pkg::TIME_W-1:0]    base_time;
    logic [pbdt_pkg::TIME_W:0]      sum;
    logic [pbdt_pkg::TIME_W-1:0]    finish;

    // handshakes
    assign in_xfer   = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == pbdt_pkg::REG_BUFFER_SIZE);
    assign out_free  = !m_valid_reg || m_tready;

    // effective capacity, clipped to the ring depth
    assign cap = (size_reg > pbdt_pkg::SIZE_W'(pbdt_pkg::BUF_DEPTH))
                 ? pbdt_pkg::CNT_W'(pbdt_pkg::BUF_DEPTH)
                 : pbdt_pkg::CNT_W'(size_reg);

    // shared compare: head entry expired at this arrival
    assign retire = (count_reg != '0)
                    && ({1'b0, arrival_reg} >= rd_data_reg);

    // admit decision and shared saturating adder
    assign empty     = (count_reg == '0);
    assign admit     = empty ? (cap != '0) : (count_reg < cap);
    assign base_time = empty ? {1'b0, arrival_reg} : last_reg;
    assign sum       = {1'b0, base_time}
                       + (pbdt_pkg::TIME_W + 1)'(ptime_reg);
    assign finish    = sum[pbdt_pkg::TIME_W] ? pbdt_pkg::TIME_MAX
                                             : sum[pbdt_pkg::TIME_W-1:0];
    assign tail_idx  = head_reg + count_reg[pbdt_pkg::IDX_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pbdt_pkg::ST_IDLE: begin
                if (in_xfer) state_next = pbdt_pkg::ST_READ;
            end
            pbdt_pkg::ST_READ: begin
                state_next = pbdt_pkg::ST_CMP;
            end
            pbdt_pkg::ST_CMP: begin
                state_next = retire ? pbdt_pkg::ST_READ : pbdt_pkg::ST_DECIDE;
            end
            pbdt_pkg::ST_DECIDE: begin
                if (out_free) state_next = pbdt_pkg::ST_IDLE;
            end
            default: state_next = pbdt_pkg::ST_IDLE;
        endcase
    end

    // datapath and output controls
    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        ring_we      = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_start_next = m_start_reg;
        m_drop_next  = m_drop_reg;
        s_tready     = 1'b0;
        case (state_reg)
            pbdt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            pbdt_pkg::ST_CMP: begin
                if (retire) begin
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            pbdt_pkg::ST_DECIDE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_drop_next  = !admit;
                    m_start_next = admit ? base_time : {1'b0, arrival_reg};
                    if (admit) begin
                        ring_we    = 1'b1;
                        last_next  = finish;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pbdt_pkg::ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            size_reg    <= pbdt_pkg::BUFFER_SIZE_RESET;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write) size_reg <= pwdata[pbdt_pkg::SIZE_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        last_reg    <= last_next;
        m_start_reg <= m_start_next;
        m_drop_reg  <= m_drop_next;
        if (in_xfer) begin
            arrival_reg <= s_tdata[pbdt_pkg::ARRIVAL_W-1:0];
            ptime_reg   <= s_tdata[pbdt_pkg::ARRIVAL_W +: pbdt_pkg::PTIME_W];
        end
    end

    // finish ring, one write and one registered head read
    always_ff @(posedge aclk) begin
        if (ring_we) ring_mem[tail_idx] <= finish;
        rd_data_reg <= ring_mem[head_reg];
    end

    // outputs
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_drop_reg;
    assign m_tdata  = {(pbdt_pkg::M_TDATA_W - pbdt_pkg::TIME_W)'(0), m_start_reg};
    assign prdata   = (paddr[2] == pbdt_pkg::REG_BUFFER_SIZE)
                      ? pbdt_pkg::PDATA_W'(size_reg) : '0;

endmodule

[tb/tb.sv]
// self-checking testbench for the drop-tail packet buffer
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [pbdt_pkg::PTIME_W-1:0]   ptime;
        logic [pbdt_pkg::ARRIVAL_W-1:0] arrival;
    } packet_t;

    typedef struct packed {
        logic                        dropped;
        logic [pbdt_pkg::TIME_W-1:0] start_tick;
    } verdict_t;

    typedef enum int {
        IDLE_SEND_LIGHT,
        IDLE_RECV_LIGHT,
        IDLE_NONE
    } idle_mode_t;

    localparam logic [pbdt_pkg::PADDR_W-1:0] ADDR_BUFFER_SIZE =
        {pbdt_pkg::REG_BUFFER_SIZE, 2'b00};
    localparam logic [pbdt_pkg::PADDR_W-1:0] ADDR_UNMAPPED = pbdt_pkg::PADDR_W'(4);
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLDOFF_LEN  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_PHASES   = 8;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pbdt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pbdt_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [pbdt_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [pbdt_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [pbdt_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // stimulus and scoreboard storage
    packet_t  pending_packets[$];
    verdict_t expected_verdicts[$];
    packet_t  packet_on_bus;
    int       error_count   = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    bit       holdoff_request = 1'b0;
    int       holdoff_left    = 0;
    int       quiet_cycles    = 0;
    logic [pbdt_pkg::ARRIVAL_W-1:0] clock_now = '0;

    // shadow state of the buffer
    logic [pbdt_pkg::TIME_W-1:0] ring_finish[pbdt_pkg::BUF_DEPTH];
    int                          ring_head  = 0;
    int                          ring_count = 0;
    logic [pbdt_pkg::SIZE_W-1:0] cfg_buffer_size = pbdt_pkg::BUFFER_SIZE_RESET;

    int phase_size[NUM_PHASES]  = '{16, 4, 1, 31, 0, 8, 2, -1};
    int phase_items[NUM_PHASES] = '{200, 150, 150, 200, 40, 150, 150, 160};
    idle_mode_t phase_mode[NUM_PHASES] = '{IDLE_SEND_LIGHT, IDLE_SEND_LIGHT, IDLE_RECV_LIGHT,
        IDLE_RECV_LIGHT, IDLE_NONE, IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE};

    packet_buffer_drop_tail u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock generation
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // retire expired finish times, then admit or drop the packet
    function automatic verdict_t admit_packet(input packet_t pkt);
        verdict_t                    v;
        int                          cap;
        logic [pbdt_pkg::TIME_W:0]   sum;
        logic [pbdt_pkg::TIME_W-1:0] st;
        cap = (cfg_buffer_size > pbdt_pkg::BUF_DEPTH) ? pbdt_pkg::BUF_DEPTH
                                                      : int'(cfg_buffer_size);
        st = {1'b0, pkt.arrival};
        v.dropped = 1'b0;
        while (ring_count > 0 && {1'b0, pkt.arrival} >= ring_finish[ring_head]) begin
            ring_head = (ring_head + 1) % pbdt_pkg::BUF_DEPTH;
            ring_count--;
        end
        if (ring_count == 0 && cap == 0) begin
            v.dropped = 1'b1;
        end else if (ring_count == 0 || ring_count < cap) begin
            if (ring_count != 0)
                st = ring_finish[(ring_head + ring_count - 1) % pbdt_pkg::BUF_DEPTH];
            sum = {1'b0, st} + pkt.ptime;
            ring_finish[(ring_head + ring_count) % pbdt_pkg::BUF_DEPTH] =
                (sum > {1'b0, pbdt_pkg::TIME_MAX}) ? pbdt_pkg::TIME_MAX
                                                   : sum[pbdt_pkg::TIME_W-1:0];
            ring_count++;
        end else begin
            v.dropped = 1'b1;
        end
        v.start_tick = st;
        return v;
    endfunction

    // input driver: predict on each transfer, then offer the next packet
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_verdicts.insert(expected_verdicts.size(),
                                         admit_packet(packet_on_bus));
            if (!s_tvalid || s_tready) begin
                if (pending_packets.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    packet_on_bus = pending_packets.pop_front();
                    s_tdata  <= {packet_on_bus.ptime, packet_on_bus.arrival};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        verdict_t want;
        bit       ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result transfer: dropped=%0b start_tick=%0h",
                           m_tuser, m_tdata[pbdt_pkg::TIME_W-1:0]);
                    error_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tuser !== want.dropped) begin
                        $error("dropped: expected %0b, actual %0b", want.dropped, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[pbdt_pkg::TIME_W-1:0] !== want.start_tick) begin
                        $error("start_tick: expected %0h, actual %0h",
                               want.start_tick, m_tdata[pbdt_pkg::TIME_W-1:0]);
                        error_count++;
                    end
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                ready_next = 1'b0;
            end else if (holdoff_request) begin
                holdoff_request = 1'b0;
                holdoff_left = HOLDOFF_LEN;
                ready_next = 1'b0;
            end else begin
                ready_next = ($urandom_range(0, 99) >= recv_idle_pct);
            end
            m_tready <= ready_next;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_packet(input logic [pbdt_pkg::ARRIVAL_W-1:0] arr,
                                input logic [pbdt_pkg::PTIME_W-1:0] pt);
        packet_t p;
        p.arrival = arr;
        p.ptime   = pt;
        pending_packets.insert(pending_packets.size(), p);
    endtask

    // write one register through a setup phase and an access phase
    task automatic write_reg(input logic [pbdt_pkg::PADDR_W-1:0] addr,
                             input logic [pbdt_pkg::SIZE_W-1:0] value);
        logic [pbdt_pkg::PDATA_W-1:0] data;
        data = ($urandom() & ~pbdt_pkg::PDATA_W'({pbdt_pkg::SIZE_W{1'b1}}))
               | pbdt_pkg::PDATA_W'(value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_BUFFER_SIZE)
            cfg_buffer_size = data[pbdt_pkg::SIZE_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block until every packet is sent and every result is back
    task automatic wait_idle();
        while (pending_packets.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge aclk);
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SEND_LIGHT: begin
                send_idle_pct = 21;
                recv_idle_pct = 75;
            end
            IDLE_RECV_LIGHT: begin
                send_idle_pct = 75;
                recv_idle_pct = 21;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // random packet: mostly small steps in time, some jumps and some late arrivals
    task automatic queue_random_packet();
        int                             pick;
        logic [pbdt_pkg::ARRIVAL_W-1:0] arr;
        logic [pbdt_pkg::PTIME_W-1:0]   pt;
        pick = $urandom_range(0, 99);
        if (pick < 2 && clock_now < 32'hF000_0000) begin
            clock_now = clock_now + $urandom_range(1 << 20, 1 << 26);
            arr = clock_now;
        end else if (pick < 6 && clock_now >= 50) begin
            arr = clock_now - $urandom_range(0, 50);
        end else begin
            clock_now = clock_now + $urandom_range(0, 30);
            arr = clock_now;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
            pt = pbdt_pkg::PTIME_W'($urandom_range(0, 40));
        else if (pick < 85)
            pt = pbdt_pkg::PTIME_W'($urandom_range(0, 400));
        else
            pt = pbdt_pkg::PTIME_W'($urandom());
        queue_packet(arr, pt);
    endtask

    // main sequence
    initial begin
        int size_sel;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        set_idle_mode(IDLE_NONE);

        // basics at the reset size: zero times, equal arrivals, longest process time
        queue_packet(32'd0, 16'd0);
        queue_packet(32'd0, 16'd0);
        queue_packet(32'd5, 16'hFFFF);
        queue_packet(32'd6, 16'd3);
        queue_packet(32'd6, 16'd0);
        wait_idle();

        // empty buffer with size zero drops everything
        write_reg(ADDR_BUFFER_SIZE, 5'd0);
        queue_packet(32'h0002_0000, 16'd7);
        queue_packet(32'h0002_0000, 16'hFFFF);
        wait_idle();

        // size above depth acts as the depth: fill up, then drop
        write_reg(ADDR_BUFFER_SIZE, 5'd31);
        write_reg(ADDR_UNMAPPED, 5'd3);
        repeat (18) queue_packet(32'h0010_0000, 16'd10);
        wait_idle();

        // size lowered while holding entries, then partly drained
        write_reg(ADDR_BUFFER_SIZE, 5'd2);
        queue_packet(32'h0010_0000, 16'd1);
        queue_packet(32'h0010_0096, 16'd1);
        wait_idle();
        clock_now = 32'h0010_0200;

        // random phases over sizes and idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            size_sel = (phase_size[ph] < 0) ? $urandom_range(0, 31) : phase_size[ph];
            write_reg(ADDR_BUFFER_SIZE, pbdt_pkg::SIZE_W'(size_sel));
            set_idle_mode(phase_mode[ph]);
            if (ph == 0 || ph == 4)
                holdoff_request = 1'b1;
            repeat (phase_items[ph]) queue_random_packet();
            wait_idle();
        end

        // top of the arrival range
        write_reg(ADDR_BUFFER_SIZE, 5'd16);
        set_idle_mode(IDLE_NONE);
        queue_packet(32'hFFFF_FFFF, 16'hFFFF);
        queue_packet(32'hFFFF_FFFF, 16'd0);
        queue_packet(32'hFFFF_FFFF, 16'hFFFF);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_verdicts.size() != 0) begin
            $error("%0d expected results never arrived", expected_verdicts.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
